### rtl/core/bmhq_pkg.sv
// Shared types and constants of the binary min-heap priority queue.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = ADDR_W + 1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] entry_key;
    logic [15:0] entry_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_key;
    logic [15:0]        out_payload;
    logic [COUNT_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] payload;
  } heap_entry_t;

endpackage

`default_nettype wire

### rtl/core/bmhq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/core/binary_min_heap_queue_top.sv
// Top level of the binary min-heap priority queue with its sift sequencer.
//
//   channel | direction | word  | contents
//   req     | in        | req_t | kind, entry_key, entry_payload
//   rsp     | out       | rsp_t | status, out_key, out_payload, occupancy
//
// A push raises rsp_valid once the entry has moved up the levels it needs (at most 10), and a pop
// once the root has been read and the last entry has moved down the levels it needs (at most 9).
// Refused words and a push into an empty heap raise rsp_valid in the cycle after acceptance.
// Reset clears the entry count and the control state; the heap RAM is not cleared.
// A new req word is taken only once the previous rsp word has been taken.
`default_nettype none

module binary_min_heap_queue_top
  import bmhq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH     = 3'd1;
  localparam logic [2:0] S_PUSH_TOP = 3'd2;
  localparam logic [2:0] S_POP_LOAD = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;

  logic [2:0]         state;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  idx;
  heap_entry_t        cur;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  heap_entry_t        wdata;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  heap_entry_t        rdata_a;
  heap_entry_t        rdata_b;

  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [ADDR_W-1:0]  push_up;
  logic [COUNT_W-1:0] left_c;
  logic [COUNT_W:0]   right_c;
  logic               left_ok;
  logic               take_right;
  heap_entry_t        pick;
  logic [COUNT_W-1:0] pick_c;
  logic [COUNT_W-1:0] next_left;
  logic               push_stop;
  logic               pop_stop;

  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign accept    = req_valid && req_ready;
  assign is_full   = count >= COUNT_W'(CAPACITY);
  assign is_empty  = count == '0;

  // Parent of the slot being filled by a push.
  assign push_up = (idx - ADDR_W'(1)) >> 1;

  // Children of the slot being filled by a pop; count already holds the reduced size.
  assign left_c     = {idx, 1'b1};
  assign right_c    = {1'b0, idx, 1'b1} + (COUNT_W + 1)'(1);
  assign left_ok    = left_c < count;
  assign take_right = (right_c < {1'b0, count}) && (rdata_b.key < rdata_a.key);
  assign pick       = take_right ? rdata_b : rdata_a;
  assign pick_c     = take_right ? right_c[COUNT_W-1:0] : left_c;
  assign next_left  = {pick_c[ADDR_W-1:0], 1'b1};

  assign push_stop = rdata_a.key <= cur.key;
  assign pop_stop  = !left_ok || (pick.key >= cur.key);

  always_comb begin
    we      = 1'b0;
    waddr   = idx;
    wdata   = cur;
    raddr_a = '0;
    raddr_b = count[ADDR_W-1:0] - ADDR_W'(1);
    case (state)
      S_IDLE: begin
        if (req.kind == KIND_PUSH) begin
          raddr_a = (count[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
        end
        if (accept && req.kind == KIND_PUSH && is_empty) begin
          we    = 1'b1;
          waddr = '0;
          wdata = '{key: req.entry_key, payload: req.entry_payload};
        end
      end
      S_PUSH: begin
        we      = 1'b1;
        raddr_a = (push_up - ADDR_W'(1)) >> 1;
        if (!push_stop) begin
          wdata = rdata_a;
        end
      end
      S_PUSH_TOP: begin
        we    = 1'b1;
        waddr = '0;
      end
      S_POP_LOAD: begin
        raddr_a = ADDR_W'(1);
        raddr_b = ADDR_W'(2);
        // A pop that leaves one entry moves the last slot straight to the root.
        if (count == COUNT_W'(1)) begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata_b;
        end
      end
      S_POP: begin
        we      = 1'b1;
        raddr_a = next_left[ADDR_W-1:0];
        raddr_b = next_left[ADDR_W-1:0] + ADDR_W'(1);
        if (!pop_stop) begin
          wdata = pick;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bmhq_ram #(
    .WIDTH($bits(heap_entry_t)),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.out_key     <= '0;
            rsp.out_payload <= '0;
            idx             <= count[ADDR_W-1:0];
            cur             <= '{key: req.entry_key, payload: req.entry_payload};
            if (req.kind == KIND_PUSH) begin
              if (is_full) begin
                rsp.status    <= STATUS_FULL;
                rsp.occupancy <= count;
                rsp_valid     <= 1'b1;
              end else begin
                rsp.status <= STATUS_OK;
                count      <= count + COUNT_W'(1);
                if (is_empty) begin
                  rsp.occupancy <= COUNT_W'(1);
                  rsp_valid     <= 1'b1;
                end else begin
                  state <= S_PUSH;
                end
              end
            end else begin
              if (is_empty) begin
                rsp.status    <= STATUS_EMPTY;
                rsp.occupancy <= '0;
                rsp_valid     <= 1'b1;
              end else begin
                rsp.status <= STATUS_OK;
                count      <= count - COUNT_W'(1);
                state      <= S_POP_LOAD;
              end
            end
          end
        end
        S_PUSH: begin
          if (push_stop) begin
            rsp.occupancy <= count;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx <= push_up;
            if (push_up == '0) begin
              state <= S_PUSH_TOP;
            end
          end
        end
        S_PUSH_TOP: begin
          rsp.occupancy <= count;
          rsp_valid     <= 1'b1;
          state         <= S_IDLE;
        end
        S_POP_LOAD: begin
          rsp.out_key     <= rdata_a.key;
          rsp.out_payload <= rdata_a.payload;
          cur             <= rdata_b;
          idx             <= '0;
          if (count <= COUNT_W'(1)) begin
            rsp.occupancy <= count;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (pop_stop) begin
            rsp.occupancy <= count;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx <= pick_c[ADDR_W-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
